>>> rtl/pswrl_pkg.sv
// shared types, constants and state encoding for the per-user sliding window rate limiter
// no dependencies; imported by pswrl_cell and the top level

package pswrl_pkg;

  localparam int USER_SLOTS_DEF = 32;
  localparam int MAX_CALLS_DEF  = 5;

  localparam int ID_W   = 16;
  localparam int TIME_W = 32;
  localparam int WIN_W  = 16;
  localparam int LIM_W  = 3;
  localparam int CFG_W  = 16;
  localparam int KEPT_W = 3;

  localparam logic [WIN_W-1:0] WINDOW_RESET = 16'd60;
  localparam logic [LIM_W-1:0] LIMIT_RESET  = 3'd5;

  // configuration register indexes
  localparam logic CFG_WINDOW = 1'b0;
  localparam logic CFG_LIMIT  = 1'b1;

  typedef struct packed {
    logic [ID_W-1:0]   requester_id;
    logic [TIME_W-1:0] now_seconds;
  } in_t;

  typedef struct packed {
    logic              allowed;
    logic [KEPT_W-1:0] calls_in_window;
  } out_t;

  // search token handed from cell to cell
  typedef struct packed {
    logic              vld;
    logic              found;
    logic [TIME_W-1:0] best_time;
  } tok_t;

  // update command broadcast to the cells
  typedef struct packed {
    logic start;
    logic evict;
  } cmd_t;

  // result returned by the updated cell
  typedef struct packed {
    logic              done;
    logic              allowed;
    logic [KEPT_W-1:0] kept;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LAUNCH,
    ST_SCAN,
    ST_UPD,
    ST_WAIT
  } state_t;

endpackage

>>> rtl/pswrl_cell.sv
// one user slot of the limiter: owner, kept times, search stage and compaction sequencer
// depends on pswrl_pkg

module pswrl_cell #(
  parameter int  USER_SLOTS = pswrl_pkg::USER_SLOTS_DEF,
  parameter int  MAX_CALLS  = pswrl_pkg::MAX_CALLS_DEF,
  parameter int  CELL_IDX   = 0,
  localparam int SLOT_W     = (USER_SLOTS > 1) ? $clog2(USER_SLOTS) : 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  pswrl_pkg::in_t             req,
  input  logic [pswrl_pkg::WIN_W-1:0] window,
  input  logic [pswrl_pkg::LIM_W-1:0] limit,
  input  pswrl_pkg::tok_t            tok_in,
  input  logic [SLOT_W-1:0]          tok_idx_in,
  output pswrl_pkg::tok_t            tok_out,
  output logic [SLOT_W-1:0]          tok_idx_out,
  input  pswrl_pkg::cmd_t            cmd,
  input  logic [SLOT_W-1:0]          cmd_idx,
  output pswrl_pkg::res_t            res
);
  import pswrl_pkg::*;

  localparam int CNT_W  = $clog2(MAX_CALLS + 1);
  localparam int CIDX_W = (MAX_CALLS > 1) ? $clog2(MAX_CALLS) : 1;

  logic                in_use_r, in_use_nxt;
  logic [ID_W-1:0]     owner_r, owner_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [TIME_W-1:0]   times_r   [MAX_CALLS];
  logic [TIME_W-1:0]   times_nxt [MAX_CALLS];
  logic                busy_r, busy_nxt;
  logic [CNT_W-1:0]    rd_r, rd_nxt;
  logic [CNT_W-1:0]    wr_r, wr_nxt;
  logic [CNT_W-1:0]    n_r, n_nxt;
  tok_t                tok_r, tok_nxt;
  logic [SLOT_W-1:0]   tok_idx_r, tok_idx_nxt;
  res_t                res_r, res_nxt;

  logic [CIDX_W-1:0]   rd_idx;
  logic [CIDX_W-1:0]   wr_idx;
  logic [TIME_W-1:0]   t_rd;
  logic                keep;
  logic [LIM_W-1:0]    lim_eff;
  logic                ok;
  logic                sel;

  assign rd_idx  = rd_r[CIDX_W-1:0];
  assign wr_idx  = wr_r[CIDX_W-1:0];
  assign t_rd    = times_r[rd_idx];
  assign keep    = (t_rd > req.now_seconds) ? (window != '0)
                 : ((req.now_seconds - t_rd) < TIME_W'(window));
  assign lim_eff = (limit > LIM_W'(MAX_CALLS)) ? LIM_W'(MAX_CALLS) : limit;
  assign ok      = LIM_W'(wr_r) < lim_eff;
  assign sel     = cmd.start && (cmd_idx == SLOT_W'(CELL_IDX));

  always_comb begin
    in_use_nxt  = in_use_r;
    owner_nxt   = owner_r;
    count_nxt   = count_r;
    times_nxt   = times_r;
    busy_nxt    = busy_r;
    rd_nxt      = rd_r;
    wr_nxt      = wr_r;
    n_nxt       = n_r;
    tok_nxt     = tok_in;
    tok_idx_nxt = tok_idx_in;
    res_nxt     = '0;

    // search stage
    if (tok_in.vld && !tok_in.found) begin
      if (!in_use_r || owner_r == req.requester_id) begin
        tok_nxt.found = 1'b1;
        tok_idx_nxt   = SLOT_W'(CELL_IDX);
      end else if (count_r != '0 && times_r[0] < tok_in.best_time) begin
        tok_nxt.best_time = times_r[0];
        tok_idx_nxt       = SLOT_W'(CELL_IDX);
      end
    end

    // update sequencer
    if (sel) begin
      in_use_nxt = 1'b1;
      owner_nxt  = req.requester_id;
      n_nxt      = cmd.evict ? '0 : count_r;
      if (cmd.evict) begin
        count_nxt = '0;
      end
      rd_nxt   = '0;
      wr_nxt   = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (rd_r != n_r) begin
        if (keep) begin
          times_nxt[wr_idx] = t_rd;
          wr_nxt            = wr_r + 1'b1;
        end
        rd_nxt = rd_r + 1'b1;
      end else begin
        if (ok) begin
          times_nxt[wr_idx] = req.now_seconds;
        end
        count_nxt       = wr_r + CNT_W'(ok);
        busy_nxt        = 1'b0;
        res_nxt.done    = 1'b1;
        res_nxt.allowed = ok;
        res_nxt.kept    = KEPT_W'(wr_r + CNT_W'(ok));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_use_r <= 1'b0;
      count_r  <= '0;
      busy_r   <= 1'b0;
      tok_r    <= '0;
      res_r    <= '0;
    end else begin
      in_use_r <= in_use_nxt;
      count_r  <= count_nxt;
      busy_r   <= busy_nxt;
      tok_r    <= tok_nxt;
      res_r    <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    owner_r   <= owner_nxt;
    times_r   <= times_nxt;
    rd_r      <= rd_nxt;
    wr_r      <= wr_nxt;
    n_r       <= n_nxt;
    tok_idx_r <= tok_idx_nxt;
  end

  assign tok_out     = tok_r;
  assign tok_idx_out = tok_idx_r;
  assign res         = res_r;

endmodule

>>> rtl/per_user_sliding_window_rate_limiter_top.sv
// top level: config registers, request control and the row of user slot cells
// depends on pswrl_pkg and pswrl_cell
// from input transfer to result: the request is registered, the search token walks the cell
// row, the chosen cell compacts the n times it keeps for the user (at most MAX_CALLS), then the result is loaded out
// throughput: one request at a time; a new one is taken only in idle, after the last result is loaded out
// reset: window 60 s, limit 5, every slot free; no clearing pass

module per_user_sliding_window_rate_limiter_top #(
  parameter int  USER_SLOTS = pswrl_pkg::USER_SLOTS_DEF,
  parameter int  MAX_CALLS  = pswrl_pkg::MAX_CALLS_DEF,
  localparam int SLOT_W     = (USER_SLOTS > 1) ? $clog2(USER_SLOTS) : 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  pswrl_pkg::in_t              in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output pswrl_pkg::out_t             out_data,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [pswrl_pkg::CFG_W-1:0] cfg_wdata
);
  import pswrl_pkg::*;

  state_t            state_r, state_nxt;
  in_t               req_r;
  logic [WIN_W-1:0]  window_r;
  logic [LIM_W-1:0]  limit_r;
  logic              out_valid_r, out_valid_nxt;
  out_t              out_data_r;
  res_t              pend_r;

  tok_t              tok     [USER_SLOTS+1];
  logic [SLOT_W-1:0] tok_idx [USER_SLOTS+1];
  res_t              res     [USER_SLOTS];
  res_t              res_any;
  cmd_t              cmd;

  logic              accept;
  logic              launch;
  logic              capture_res;
  logic              load_out;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_LAUNCH;
      end
      ST_LAUNCH: begin
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (tok[USER_SLOTS].vld) state_nxt = ST_UPD;
      end
      ST_UPD: begin
        if (res_any.done) state_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state outputs
  always_comb begin
    in_stall    = 1'b1;
    launch      = 1'b0;
    cmd         = '0;
    capture_res = 1'b0;
    load_out    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
      end
      ST_LAUNCH: begin
        launch = 1'b1;
      end
      ST_SCAN: begin
        cmd.start = tok[USER_SLOTS].vld;
        cmd.evict = !tok[USER_SLOTS].found;
      end
      ST_UPD: begin
        capture_res = res_any.done;
      end
      ST_WAIT: begin
        load_out = !out_valid_r || !out_stall;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  assign accept = in_valid && !in_stall;

  // search token entry
  assign tok[0]     = '{vld: launch, found: 1'b0, best_time: req_r.now_seconds};
  assign tok_idx[0] = '0;

  for (genvar g = 0; g < USER_SLOTS; g++) begin : g_cell
    pswrl_cell #(
      .USER_SLOTS(USER_SLOTS),
      .MAX_CALLS (MAX_CALLS),
      .CELL_IDX  (g)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .req        (req_r),
      .window     (window_r),
      .limit      (limit_r),
      .tok_in     (tok[g]),
      .tok_idx_in (tok_idx[g]),
      .tok_out    (tok[g+1]),
      .tok_idx_out(tok_idx[g+1]),
      .cmd        (cmd),
      .cmd_idx    (tok_idx[USER_SLOTS]),
      .res        (res[g])
    );
  end

  // only the updated cell drives a nonzero result
  always_comb begin
    res_any = '0;
    for (int i = 0; i < USER_SLOTS; i++) begin
      res_any = res_any | res[i];
    end
  end

  assign out_valid_nxt = (out_valid_r && out_stall) || load_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      window_r    <= WINDOW_RESET;
      limit_r     <= LIMIT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_WINDOW: window_r <= cfg_wdata[WIN_W-1:0];
          CFG_LIMIT:  limit_r  <= cfg_wdata[LIM_W-1:0];
          default:    window_r <= window_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_data;
    end
    if (capture_res) begin
      pend_r <= res_any;
    end
    if (load_out) begin
      out_data_r.allowed         <= pend_r.allowed;
      out_data_r.calls_in_window <= pend_r.kept;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
